// ===== rtl/core/cca_pkg.sv =====
// Shared constants for the cluster chain allocator: op codes, status codes
// and the table word marks. No dependencies.
package cca_pkg;

  localparam int OP_W = 3;
  localparam int ST_W = 2;

  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd1;
  localparam logic [OP_W-1:0] OP_EXTEND = 3'd2;
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [31:0] END_LIMIT  = 32'h0fff_fff8;
  localparam logic [31:0] END_MARK   = 32'h0fff_ffff;
  localparam int          FIRST_DATA = 2;

endpackage

// ===== rtl/core/cluster_chain_allocator.sv =====
// Cluster chain allocator top level: sequencer around one table RAM.
// Depends on cca_pkg and cca_ram.
//
//  channel  ports                                       handshake
//  -------  ------------------------------------------  -------------------------
//  input    in_op in_cluster in_count in_entry_value     start && !busy
//  result   out_result_cluster out_chain_end             out_strobe, one cycle
//           out_entry_word out_status
//  config   cfg_write_data                               cfg_write_en
//
// Write, unknown and out-of-range ops answer from idle; lookup and read answer in S_LOOK
// on the registered RAM read data. Allocate: a count pass reads entries FIRST_DATA..lim-1,
// then a link pass rescans to the last cluster taken (lim = min(clusters_in_use, entries)).
// Extend first walks the chain, S_WALK_RD then S_WALK_CHK per entry visited, tail included.
// After reset a clearing pass writes zero to every table entry and holds busy high.
// Results go out as a one-cycle strobe; the receiver cannot stall.
module cluster_chain_allocator #(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [11:0] in_cluster,
  input  logic [12:0] in_count,
  input  logic [31:0] in_entry_value,
  output logic        out_strobe,
  output logic [11:0] out_result_cluster,
  output logic        out_chain_end,
  output logic [31:0] out_entry_word,
  output logic [1:0]  out_status,
  input  logic        cfg_write_en,
  input  logic [12:0] cfg_write_data
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = $clog2(TABLE_ENTRIES + 2);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_LOOK     = 4'd2;
  localparam logic [3:0] S_WALK_RD  = 4'd3;
  localparam logic [3:0] S_WALK_CHK = 4'd4;
  localparam logic [3:0] S_COUNT    = 4'd5;
  localparam logic [3:0] S_LINK     = 4'd6;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [12:0]   cfg_r, cfg_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          out_strobe_r, out_strobe_nxt;

  logic [2:0]    op_r, op_nxt;
  logic [12:0]   need_r, need_nxt;
  logic [12:0]   done_r, done_nxt;
  logic [AW-1:0] cur_r, cur_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic          has_tail_r, has_tail_nxt;
  logic [SW-1:0] steps_r, steps_nxt;
  logic [CW-1:0] sp_r, sp_nxt;
  logic [CW-1:0] free_r, free_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;

  logic [11:0]   res_r, res_nxt;
  logic          end_r, end_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [1:0]    st_r, st_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [31:0]   ram_rdata;

  logic          accept;
  logic          in_range;
  logic [AW-1:0] in_idx;
  logic [CW-1:0] lim;

  cca_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = 32'(in_cluster) < 32'(TABLE_ENTRIES);
  assign in_idx   = AW'(in_cluster);

  // free scan stops at the smaller of the register and the table size
  always_comb begin
    if (32'(cfg_r) >= 32'(TABLE_ENTRIES)) begin
      lim = CW'(TABLE_ENTRIES);
    end else begin
      lim = CW'(cfg_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cfg_nxt        = cfg_r;
    rd_pend_nxt    = 1'b0;
    out_strobe_nxt = 1'b0;
    op_nxt         = op_r;
    need_nxt       = need_r;
    done_nxt       = done_r;
    cur_nxt        = cur_r;
    head_nxt       = head_r;
    has_tail_nxt   = has_tail_r;
    steps_nxt      = steps_r;
    sp_nxt         = sp_r;
    free_nxt       = free_r;
    rd_idx_nxt     = rd_idx_r;
    res_nxt        = '0;
    end_nxt        = 1'b0;
    word_nxt       = '0;
    st_nxt         = cca_pkg::ST_OK;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = '0;
    ram_raddr      = sp_r[AW-1:0];

    if (cfg_write_en) begin
      cfg_nxt = cfg_write_data;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(TABLE_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        ram_raddr = in_idx;
        if (accept) begin
          op_nxt  = in_op;
          cur_nxt = in_idx;
          case (in_op)
            cca_pkg::OP_LOOKUP, cca_pkg::OP_READ: begin
              if (in_range) begin
                state_nxt = S_LOOK;
              end else begin
                out_strobe_nxt = 1'b1;
                st_nxt         = cca_pkg::ST_RANGE;
              end
            end
            cca_pkg::OP_ALLOC: begin
              need_nxt     = (in_count == 13'd0) ? 13'd1 : in_count;
              has_tail_nxt = 1'b0;
              sp_nxt       = CW'(cca_pkg::FIRST_DATA);
              free_nxt     = '0;
              state_nxt    = S_COUNT;
            end
            cca_pkg::OP_EXTEND: begin
              if (in_range) begin
                need_nxt     = in_count;
                has_tail_nxt = 1'b1;
                steps_nxt    = '0;
                state_nxt    = S_WALK_RD;
              end else begin
                out_strobe_nxt = 1'b1;
                st_nxt         = cca_pkg::ST_RANGE;
              end
            end
            cca_pkg::OP_WRITE: begin
              out_strobe_nxt = 1'b1;
              if (in_range) begin
                ram_we    = 1'b1;
                ram_waddr = in_idx;
                ram_wdata = in_entry_value;
              end else begin
                st_nxt = cca_pkg::ST_RANGE;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_LOOK: begin
        out_strobe_nxt = 1'b1;
        state_nxt      = S_IDLE;
        if (op_r == cca_pkg::OP_LOOKUP) begin
          if (ram_rdata >= cca_pkg::END_LIMIT) begin
            end_nxt = 1'b1;
          end else begin
            res_nxt = ram_rdata[11:0];
          end
        end else begin
          word_nxt = ram_rdata;
        end
      end

      S_WALK_RD: begin
        ram_raddr = cur_r;
        state_nxt = S_WALK_CHK;
      end

      S_WALK_CHK: begin
        if (ram_rdata >= cca_pkg::END_LIMIT) begin
          sp_nxt    = CW'(cca_pkg::FIRST_DATA);
          free_nxt  = '0;
          state_nxt = S_COUNT;
        end else begin
          steps_nxt = steps_r + SW'(1);
          // link out of the table or a walk longer than the table: cycle
          if (ram_rdata >= 32'(TABLE_ENTRIES) ||
              32'(steps_r) + 32'd1 > 32'(TABLE_ENTRIES)) begin
            out_strobe_nxt = 1'b1;
            st_nxt         = cca_pkg::ST_RANGE;
            state_nxt      = S_IDLE;
          end else begin
            cur_nxt   = AW'(ram_rdata);
            state_nxt = S_WALK_RD;
          end
        end
      end

      S_COUNT: begin
        if (sp_r < lim) begin
          rd_pend_nxt = 1'b1;
          rd_idx_nxt  = sp_r[AW-1:0];
          sp_nxt      = sp_r + CW'(1);
        end
        if (rd_pend_r && ram_rdata == 32'd0) begin
          free_nxt = free_r + CW'(1);
        end
        if (sp_r >= lim && !rd_pend_r) begin
          if (32'(free_r) < 32'(need_r)) begin
            out_strobe_nxt = 1'b1;
            st_nxt         = cca_pkg::ST_NOSPACE;
            state_nxt      = S_IDLE;
          end else begin
            sp_nxt    = CW'(cca_pkg::FIRST_DATA);
            done_nxt  = '0;
            state_nxt = S_LINK;
          end
        end
      end

      S_LINK: begin
        if (done_r == need_r) begin
          // close the chain; a read still in flight is dropped
          ram_we         = 1'b1;
          ram_waddr      = cur_r;
          ram_wdata      = cca_pkg::END_MARK;
          out_strobe_nxt = 1'b1;
          res_nxt        = 12'((op_r == cca_pkg::OP_ALLOC) ? head_r : cur_r);
          state_nxt      = S_IDLE;
        end else begin
          if (sp_r < lim) begin
            rd_pend_nxt = 1'b1;
            rd_idx_nxt  = sp_r[AW-1:0];
            sp_nxt      = sp_r + CW'(1);
          end
          // tail is behind the scan or a used chain end, so never the word in flight
          if (rd_pend_r && ram_rdata == 32'd0) begin
            if (has_tail_r) begin
              ram_we    = 1'b1;
              ram_waddr = cur_r;
              ram_wdata = 32'(rd_idx_r);
            end else begin
              head_nxt = rd_idx_r;
            end
            cur_nxt      = rd_idx_r;
            has_tail_nxt = 1'b1;
            done_nxt     = done_r + 13'd1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      cfg_r        <= 13'd4096;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      cfg_r        <= cfg_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    need_r     <= need_nxt;
    done_r     <= done_nxt;
    cur_r      <= cur_nxt;
    head_r     <= head_nxt;
    has_tail_r <= has_tail_nxt;
    steps_r    <= steps_nxt;
    sp_r       <= sp_nxt;
    free_r     <= free_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_r      <= res_nxt;
    end_r      <= end_nxt;
    word_r     <= word_nxt;
    st_r       <= st_nxt;
  end

  assign out_strobe         = out_strobe_r;
  assign out_result_cluster = res_r;
  assign out_chain_end      = end_r;
  assign out_entry_word     = word_r;
  assign out_status         = st_r;

`ifndef SYNTHESIS
  a_err_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_status != cca_pkg::ST_OK |->
      out_result_cluster == 12'd0 && out_entry_word == 32'd0 && !out_chain_end)
    else $error("error word carries nonzero fields");

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == cca_pkg::OP_WRITE |=> out_strobe)
    else $error("write entry did not answer in one cycle");

  a_end_no_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_chain_end |-> out_result_cluster == 12'd0)
    else $error("chain end word with a cluster index");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result word while sequencer still busy");

  a_link_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LINK |-> done_r <= need_r)
    else $error("link pass overran its cluster count");
`endif

endmodule

// ===== rtl/core/cca_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/cluster_chain_allocator_tb.sv =====
// Testbench for cluster_chain_allocator: directed and random table traffic
// checked against a cycle-free table model kept in the bench.
// Depends on cca_pkg and the allocator RTL.
module cluster_chain_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_N        = 4096;
  localparam int COUNT_MAX      = 4096;
  localparam int WALK_CAP       = 256;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int END_WAIT       = 64;

  typedef struct packed {
    logic [cca_pkg::OP_W-1:0] op;
    logic [11:0]              cluster;
    logic [12:0]              count;
    logic [31:0]              value;
  } table_cmd_t;

  typedef struct packed {
    logic [11:0]              cluster;
    logic                     chain_end;
    logic [31:0]              word;
    logic [cca_pkg::ST_W-1:0] status;
  } table_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_op = '0;
  logic [11:0] in_cluster = '0;
  logic [12:0] in_count = '0;
  logic [31:0] in_entry_value = '0;
  logic        out_strobe;
  logic [11:0] out_result_cluster;
  logic        out_chain_end;
  logic [31:0] out_entry_word;
  logic [1:0]  out_status;
  logic        cfg_write_en = 1'b0;
  logic [12:0] cfg_write_data = '0;

  // model state
  bit   [31:0] fat [TABLE_N];
  logic [12:0] cfg_scan = 13'd4096;

  table_reply_t pending_replies[$];
  int fault_count = 0;
  int stall_cycles = 0;
  int idle_pct = 0;
  int long_walks_left = 4;

  always #4 clk = ~clk;

  cluster_chain_allocator #(.TABLE_ENTRIES(TABLE_N)) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_cluster         (in_cluster),
    .in_count           (in_count),
    .in_entry_value     (in_entry_value),
    .out_strobe         (out_strobe),
    .out_result_cluster (out_result_cluster),
    .out_chain_end      (out_chain_end),
    .out_entry_word     (out_entry_word),
    .out_status         (out_status),
    .cfg_write_en       (cfg_write_en),
    .cfg_write_data     (cfg_write_data)
  );

  // ---------------------------------------------------------------- model

  function automatic int unsigned scan_top();
    return (cfg_scan > TABLE_N) ? TABLE_N : cfg_scan;
  endfunction

  function automatic int unsigned free_total();
    int unsigned n = 0;
    for (int unsigned i = cca_pkg::FIRST_DATA; i < scan_top(); i++)
      if (fat[i] == 0) n++;
    return n;
  endfunction

  // follows links to the end mark; a link off the table or a loop is a range error
  function automatic logic [cca_pkg::ST_W-1:0] find_chain_tail(input logic [11:0] head,
                                                               output int unsigned tail,
                                                               output int unsigned steps);
    logic [cca_pkg::ST_W-1:0] st;
    logic [31:0] link;
    st = cca_pkg::ST_OK;
    tail = head;
    steps = 0;
    while (st == cca_pkg::ST_OK && fat[tail] < cca_pkg::END_LIMIT) begin
      link = fat[tail];
      steps++;
      if (link >= TABLE_N || steps > TABLE_N) st = cca_pkg::ST_RANGE;
      else tail = link;
    end
    return st;
  endfunction

  function automatic int unsigned link_clusters(int unsigned tail, int unsigned n);
    int unsigned cur, done;
    cur = tail;
    done = 0;
    for (int unsigned cand = cca_pkg::FIRST_DATA; cand < scan_top() && done < n; cand++) begin
      if (fat[cand] == 0) begin
        fat[cur] = cand;
        cur = cand;
        done++;
      end
    end
    fat[cur] = cca_pkg::END_MARK;
    return cur;
  endfunction

  function automatic table_reply_t predict_table_op(table_cmd_t c);
    table_reply_t r;
    int unsigned tail, steps, need, first;
    r = '0;
    case (c.op)
      cca_pkg::OP_LOOKUP: begin
        if (fat[c.cluster] >= cca_pkg::END_LIMIT) r.chain_end = 1'b1;
        else begin
          tail = fat[c.cluster];
          r.cluster = tail[11:0];
        end
      end
      cca_pkg::OP_ALLOC: begin
        need = (c.count == 0) ? 1 : c.count;
        if (free_total() < need) r.status = cca_pkg::ST_NOSPACE;
        else begin
          first = cca_pkg::FIRST_DATA;
          while (first < scan_top() && fat[first] != 0) first++;
          fat[first] = cca_pkg::END_MARK;
          tail = link_clusters(first, need - 1);
          r.cluster = first[11:0];
        end
      end
      cca_pkg::OP_EXTEND: begin
        r.status = find_chain_tail(c.cluster, tail, steps);
        if (r.status == cca_pkg::ST_OK) begin
          if (free_total() < c.count) r.status = cca_pkg::ST_NOSPACE;
          else begin
            tail = link_clusters(tail, c.count);
            r.cluster = tail[11:0];
          end
        end
      end
      cca_pkg::OP_WRITE: fat[c.cluster] = c.value;
      cca_pkg::OP_READ:  r.word = fat[c.cluster];
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic table_cmd_t make_word(logic [cca_pkg::OP_W-1:0] op, int unsigned cluster,
                                           int unsigned count, logic [31:0] value);
    table_cmd_t c;
    c.op = op;
    c.cluster = cluster[11:0];
    c.count = count[12:0];
    c.value = value;
    return c;
  endfunction

  function automatic table_cmd_t rand_word();
    table_cmd_t c;
    int unsigned pick, near_top, tail, steps;
    logic [cca_pkg::ST_W-1:0] walk_st;
    near_top = scan_top() + 8;
    if (near_top > TABLE_N - 1) near_top = TABLE_N - 1;
    pick = ($urandom_range(9) < 8) ? $urandom_range(near_top) : $urandom_range(TABLE_N - 1);
    c.cluster = pick[11:0];
    pick = $urandom_range(99);
    if (pick < 15) c.op = cca_pkg::OP_LOOKUP;
    else if (pick < 35) c.op = cca_pkg::OP_ALLOC;
    else if (pick < 55) c.op = cca_pkg::OP_EXTEND;
    else if (pick < 80) c.op = cca_pkg::OP_WRITE;
    else if (pick < 95) c.op = cca_pkg::OP_READ;
    else begin
      pick = $urandom_range(2**cca_pkg::OP_W - 1, cca_pkg::OP_READ + 1);
      c.op = pick[cca_pkg::OP_W-1:0];
    end
    pick = $urandom_range(9);
    if (pick < 7) pick = $urandom_range(3);
    else if (pick < 9) pick = $urandom_range(scan_top());
    else pick = $urandom_range(COUNT_MAX);
    c.count = pick[12:0];
    c.value = $urandom;
    if (c.op == cca_pkg::OP_WRITE) begin
      pick = $urandom_range(19);
      if (pick < 8) c.value = '0;
      else if (pick < 11) c.value = cca_pkg::END_MARK;
      else if (pick < 13) c.value = $urandom_range(32'hffff_ffff, cca_pkg::END_LIMIT);
      else if (pick < 17)
        c.value = (c.cluster < near_top) ? $urandom_range(near_top, c.cluster + 1)
                                         : cca_pkg::END_MARK;
      else if (pick < 18) c.value = $urandom_range(near_top);
    end
    if (c.op == cca_pkg::OP_EXTEND) begin
      walk_st = find_chain_tail(c.cluster, tail, steps);
      if (steps > WALK_CAP) begin
        if (long_walks_left > 0) long_walks_left--;
        else begin
          // cut the loop or the chain instead of paying for another long walk
          c.op = cca_pkg::OP_WRITE;
          c.value = cca_pkg::END_MARK;
          if (walk_st == cca_pkg::ST_RANGE) c.cluster = tail[11:0];
        end
      end
    end
    return c;
  endfunction

  task automatic issue_word(input table_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_op <= c.op;
    in_cluster <= c.cluster;
    in_count <= c.count;
    in_entry_value <= c.value;
    do @(posedge clk); while (busy);
    pending_replies.push_back(predict_table_op(c));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0 || busy);
  endtask

  task automatic program_scan_limit(input int unsigned lim);
    wait_idle();
    cfg_write_en <= 1'b1;
    cfg_write_data <= lim[12:0];
    @(posedge clk);
    cfg_write_en <= 1'b0;
    cfg_scan = lim[12:0];
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_unknown_ops();
    issue_word(make_word(cca_pkg::OP_LOOKUP, 0, 0, '0));
    for (int o = cca_pkg::OP_READ + 1; o < 2**cca_pkg::OP_W; o++)
      issue_word(make_word(o[cca_pkg::OP_W-1:0], TABLE_N - 1, COUNT_MAX, '1));
  endtask

  task automatic test_entry_access();
    issue_word(make_word(cca_pkg::OP_WRITE, TABLE_N - 1, 0, 32'hffff_ffff));
    issue_word(make_word(cca_pkg::OP_READ, TABLE_N - 1, 0, '0));
    issue_word(make_word(cca_pkg::OP_LOOKUP, TABLE_N - 1, 0, '0));
    // link above the table: lookup reports its low bits
    issue_word(make_word(cca_pkg::OP_WRITE, 100, 0, 32'h0abc_1234));
    issue_word(make_word(cca_pkg::OP_LOOKUP, 100, 0, '0));
    issue_word(make_word(cca_pkg::OP_READ, 0, 0, '0));
  endtask

  task automatic test_allocate();
    program_scan_limit(16);
    issue_word(make_word(cca_pkg::OP_ALLOC, 0, 0, '0));
    issue_word(make_word(cca_pkg::OP_ALLOC, 0, 3, '0));
    issue_word(make_word(cca_pkg::OP_ALLOC, 0, COUNT_MAX, '0));
  endtask

  task automatic test_extend();
    issue_word(make_word(cca_pkg::OP_EXTEND, cca_pkg::FIRST_DATA, 0, '0));
    issue_word(make_word(cca_pkg::OP_EXTEND, cca_pkg::FIRST_DATA + 1, 2, '0));
    issue_word(make_word(cca_pkg::OP_EXTEND, cca_pkg::FIRST_DATA + 2, 1, '0));
  endtask

  task automatic test_broken_chain();
    issue_word(make_word(cca_pkg::OP_WRITE, 12, 0, TABLE_N + 1000));
    issue_word(make_word(cca_pkg::OP_EXTEND, 12, 1, '0));
    // self loop: the walk runs out of steps
    issue_word(make_word(cca_pkg::OP_WRITE, 12, 0, 12));
    issue_word(make_word(cca_pkg::OP_EXTEND, 12, 1, '0));
    issue_word(make_word(cca_pkg::OP_WRITE, 12, 0, '0));
  endtask

  task automatic test_scan_limits();
    program_scan_limit(3);
    issue_word(make_word(cca_pkg::OP_ALLOC, 0, 1, '0));
    issue_word(make_word(cca_pkg::OP_WRITE, cca_pkg::FIRST_DATA, 0, '0));
    issue_word(make_word(cca_pkg::OP_ALLOC, 0, 1, '0));
    program_scan_limit(TABLE_N);
    issue_word(make_word(cca_pkg::OP_ALLOC, 0, COUNT_MAX, '0));
    // free clusters link to 0, so give 0 an end mark before walking through it
    issue_word(make_word(cca_pkg::OP_WRITE, 0, 0, cca_pkg::END_MARK));
    issue_word(make_word(cca_pkg::OP_EXTEND, 4000, 1, '0));
  endtask

  task automatic run_phase(int unsigned lim_lo, int unsigned lim_hi, int pct, int n);
    program_scan_limit($urandom_range(lim_hi, lim_lo));
    idle_pct = pct;
    repeat (n) issue_word(rand_word());
  endtask

  task automatic test_random_traffic();
    run_phase(3, 40, 0, 400);
    run_phase(20, 200, 63, 400);
    run_phase(3, 3, 17, 200);
    run_phase(40, 100, 17, 450);
    run_phase(TABLE_N, TABLE_N, 0, 40);
    run_phase(8, 24, 63, 120);
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin : check_results
    table_reply_t want;
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        $error("result word with nothing expected");
        fault_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_result_cluster !== want.cluster) begin
          $error("result_cluster: expected %0d, actual %0d", want.cluster, out_result_cluster);
          fault_count++;
        end
        if (out_chain_end !== want.chain_end) begin
          $error("chain_end: expected %0d, actual %0d", want.chain_end, out_chain_end);
          fault_count++;
        end
        if (out_entry_word !== want.word) begin
          $error("entry_word: expected %h, actual %h", want.word, out_entry_word);
          fault_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          fault_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_unknown_ops();
    test_entry_access();
    test_allocate();
    test_extend();
    test_broken_chain();
    test_scan_limits();
    test_random_traffic();
    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $error("%0d result words never arrived", pending_replies.size());
      fault_count++;
    end
    if (fault_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cca_pkg.sv
rtl/core/cca_ram.sv
rtl/core/cluster_chain_allocator.sv
tb/cluster_chain_allocator_tb.sv
